// ===== hw/rtl/scaled_bitmap_pixel_render_assert.svh =====
// Assertion macros used by the top level of the pixel renderer.
`ifndef SCALED_BITMAP_PIXEL_RENDER_ASSERT_SVH
`define SCALED_BITMAP_PIXEL_RENDER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled_bitmap_pixel_render: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled_bitmap_pixel_render: assertion failed");

`endif

// ===== hw/rtl/sbpr_pkg.sv =====
`default_nettype none

package sbpr_pkg;

    localparam int BITMAP_WIDTH  = 128;
    localparam int BITMAP_HEIGHT = 64;
    localparam int IMAGE_COUNT   = 16;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 240;

    localparam int ROW_BYTES  = (BITMAP_WIDTH + 7) / 8;
    localparam int STORE_SIZE = IMAGE_COUNT * BITMAP_HEIGHT * ROW_BYTES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // Quotient widths of the two coordinate divisions.
    localparam int BX_W = $clog2(BITMAP_WIDTH);
    localparam int BY_W = (BITMAP_HEIGHT > 1) ? $clog2(BITMAP_HEIGHT) : 1;

    localparam int DIV_STEPS       = (BX_W > BY_W) ? BX_W : BY_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam int FACE_W  = 8;
    localparam int SCR_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int COORD_W = $clog2(SCR_MAX + 1) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACE_WIDTH   = 3'd0,
        CFG_FACE_HEIGHT  = 3'd1,
        CFG_BASE_COLOR   = 3'd2,
        CFG_SHIFT_X      = 3'd3,
        CFG_SHIFT_Y      = 3'd4,
        CFG_BRIGHTNESS   = 3'd5,
        CFG_INVERT       = 3'd6,
        CFG_IMAGE_SELECT = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_FETCH = 1'b1
    } t_mode;

    typedef struct packed {
        logic [7:0]        face_width;
        logic [7:0]        face_height;
        logic [23:0]       base_color;
        logic signed [7:0] shift_x;
        logic signed [7:0] shift_y;
        logic [7:0]        brightness;
        logic              invert;
        logic [3:0]        image_select;
    } t_cfg;

    typedef struct packed {
        logic       mode;
        logic [3:0] image_slot;
        logic [5:0] bitmap_row;
        logic [3:0] bitmap_byte_col;
        logic [7:0] bitmap_data;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
    } t_item;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        logic              fetch;
        logic              act;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_tag;

    typedef struct packed {
        logic        lit;
        logic [15:0] pixel_565;
        logic [23:0] pixel_8888;
    } t_pix;

endpackage

`default_nettype wire

// ===== hw/rtl/sbpr_if.sv =====
`default_nettype none

interface sbpr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] image_slot;
    logic [5:0] bitmap_row;
    logic [3:0] bitmap_byte_col;
    logic [7:0] bitmap_data;
    logic [7:0] screen_x;
    logic [7:0] screen_y;

    modport source (
        output valid, mode, image_slot, bitmap_row, bitmap_byte_col, bitmap_data,
        output screen_x, screen_y,
        input  ready
    );
    modport sink (
        input  valid, mode, image_slot, bitmap_row, bitmap_byte_col, bitmap_data,
        input  screen_x, screen_y,
        output ready
    );
endinterface

interface sbpr_out_if;
    logic        valid;
    logic        ready;
    logic        lit;
    logic [15:0] pixel_565;
    logic [23:0] pixel_8888;

    modport source (output valid, lit, pixel_565, pixel_8888, input ready);
    modport sink (input valid, lit, pixel_565, pixel_8888, output ready);
endinterface

interface sbpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbpr_ram.sv =====
`default_nettype none

module sbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/sbpr_window.sv =====
`default_nettype none

module sbpr_window
    import sbpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_vld,
    input  wire t_item             i_item,
    output logic                   o_vld,
    output t_tag                   o_tag,
    output logic [FACE_W-1:0]      o_lx,
    output logic [FACE_W-1:0]      o_ly,
    output logic [FACE_W-1:0]      o_fw,
    output logic [FACE_W-1:0]      o_fh
);

    function automatic logic [FACE_W-1:0] clamp_size(input logic [FACE_W-1:0] v,
                                                     input int limit);
        if (v == '0) begin
            return FACE_W'(1);
        end
        if (32'(v) > limit) begin
            return FACE_W'(limit);
        end
        return v;
    endfunction

    // Window geometry is registered from the configuration registers; it settles in the cycle after a write.
    logic [FACE_W-1:0]         r_fw, r_fh, n_fw, n_fh;
    logic signed [COORD_W-1:0] r_x0, r_y0, n_x0, n_y0;

    logic  r_s1_vld;
    t_item r_s1_item;

    logic              r_s2_vld;
    t_tag              r_s2_tag;
    logic [FACE_W-1:0] r_s2_lx, r_s2_ly;

    logic signed [COORD_W-1:0] lx, ly;
    logic                      in_x, in_y, scr_ok, load_ok;
    t_tag                      n_tag;

    always_comb begin
        n_fw = clamp_size(i_cfg.face_width, SCREEN_WIDTH);
        n_fh = clamp_size(i_cfg.face_height, SCREEN_HEIGHT);
        n_x0 = $signed((COORD_W'(SCREEN_WIDTH) - COORD_W'(n_fw)) >> 1)
             + $signed({{(COORD_W-8){i_cfg.shift_x[7]}}, i_cfg.shift_x});
        n_y0 = $signed((COORD_W'(SCREEN_HEIGHT) - COORD_W'(n_fh)) >> 1)
             + $signed({{(COORD_W-8){i_cfg.shift_y[7]}}, i_cfg.shift_y});
    end

    always_ff @(posedge i_clk) begin
        r_fw <= n_fw;
        r_fh <= n_fh;
        r_x0 <= n_x0;
        r_y0 <= n_y0;
    end

    always_comb begin
        lx      = $signed(COORD_W'(r_s1_item.screen_x)) - r_x0;
        ly      = $signed(COORD_W'(r_s1_item.screen_y)) - r_y0;
        in_x    = !lx[COORD_W-1] && (lx < $signed(COORD_W'(r_fw)));
        in_y    = !ly[COORD_W-1] && (ly < $signed(COORD_W'(r_fh)));
        scr_ok  = (32'(r_s1_item.screen_x) < SCREEN_WIDTH)
               && (32'(r_s1_item.screen_y) < SCREEN_HEIGHT);
        load_ok = (32'(r_s1_item.image_slot) < IMAGE_COUNT)
               && (32'(r_s1_item.bitmap_row) < BITMAP_HEIGHT)
               && (32'(r_s1_item.bitmap_byte_col) < ROW_BYTES);

        n_tag.fetch = (r_s1_item.mode == MODE_FETCH);
        n_tag.act   = n_tag.fetch ? (scr_ok && in_x && in_y) : load_ok;
        n_tag.addr  = ADDR_W'((32'(r_s1_item.image_slot) * BITMAP_HEIGHT
                              + 32'(r_s1_item.bitmap_row)) * ROW_BYTES
                              + 32'(r_s1_item.bitmap_byte_col));
        n_tag.data  = r_s1_item.bitmap_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item <= i_item;
            r_s2_tag  <= n_tag;
            r_s2_lx   <= lx[FACE_W-1:0];
            r_s2_ly   <= ly[FACE_W-1:0];
        end
    end

    assign o_vld = r_s2_vld;
    assign o_tag = r_s2_tag;
    assign o_lx  = r_s2_lx;
    assign o_ly  = r_s2_ly;
    assign o_fw  = r_fw;
    assign o_fh  = r_fh;

endmodule

`default_nettype wire

// ===== hw/rtl/sbpr_scaler.sv =====
`default_nettype none

// Pipelined restoring division of both local coordinates:
// bx = lx * BITMAP_WIDTH / fw and by = ly * BITMAP_HEIGHT / fh.
module sbpr_scaler
    import sbpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire t_tag              i_tag,
    input  wire logic [FACE_W-1:0] i_lx,
    input  wire logic [FACE_W-1:0] i_ly,
    input  wire logic [FACE_W-1:0] i_fw,
    input  wire logic [FACE_W-1:0] i_fh,
    output logic                   o_vld,
    output t_tag                   o_tag,
    output logic [BX_W-1:0]        o_bx,
    output logic [BY_W-1:0]        o_by
);

    logic              r_vld [DIV_STAGES];
    t_tag              r_tag [DIV_STAGES];
    logic [FACE_W:0]   r_ax  [DIV_STAGES];
    logic [FACE_W:0]   r_ay  [DIV_STAGES];
    logic [BX_W-1:0]   r_qx  [DIV_STAGES];
    logic [BY_W-1:0]   r_qy  [DIV_STAGES];

    // The quotient fits its width because lx < fw, so the upper part of the
    // numerator starts below the divisor.
    logic [FACE_W+BX_W-1:0] num_x;
    logic [FACE_W+BY_W-1:0] num_y;

    assign num_x = (FACE_W+BX_W)'(i_lx) * (FACE_W+BX_W)'(BITMAP_WIDTH);
    assign num_y = (FACE_W+BY_W)'(i_ly) * (FACE_W+BY_W)'(BITMAP_HEIGHT);

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic            src_vld;
        t_tag            src_tag;
        logic [FACE_W:0] src_ax, src_ay, n_ax, n_ay;
        logic [BX_W-1:0] src_qx, n_qx;
        logic [BY_W-1:0] src_qy, n_qy;

        if (s == 0) begin : g_head
            assign src_vld = i_vld;
            assign src_tag = i_tag;
            assign src_ax  = (FACE_W+1)'(num_x >> BX_W);
            assign src_ay  = (FACE_W+1)'(num_y >> BY_W);
            assign src_qx  = num_x[BX_W-1:0];
            assign src_qy  = num_y[BY_W-1:0];
        end else begin : g_body
            assign src_vld = r_vld[s-1];
            assign src_tag = r_tag[s-1];
            assign src_ax  = r_ax[s-1];
            assign src_ay  = r_ay[s-1];
            assign src_qx  = r_qx[s-1];
            assign src_qy  = r_qy[s-1];
        end

        always_comb begin
            logic bit_x;
            logic bit_y;
            n_ax = src_ax;
            n_ay = src_ay;
            n_qx = src_qx;
            n_qy = src_qy;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (s * STEPS_PER_STAGE + j < BX_W) begin
                    n_ax  = {n_ax[FACE_W-1:0], n_qx[BX_W-1]};
                    bit_x = (n_ax >= {1'b0, i_fw});
                    if (bit_x) begin
                        n_ax = n_ax - {1'b0, i_fw};
                    end
                    n_qx = (n_qx << 1) | BX_W'(bit_x);
                end
                if (s * STEPS_PER_STAGE + j < BY_W) begin
                    n_ay  = {n_ay[FACE_W-1:0], n_qy[BY_W-1]};
                    bit_y = (n_ay >= {1'b0, i_fh});
                    if (bit_y) begin
                        n_ay = n_ay - {1'b0, i_fh};
                    end
                    n_qy = (n_qy << 1) | BY_W'(bit_y);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= src_tag;
                r_ax[s]  <= n_ax;
                r_ay[s]  <= n_ay;
                r_qx[s]  <= n_qx;
                r_qy[s]  <= n_qy;
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_tag = r_tag[DIV_STAGES-1];
    assign o_bx  = r_qx[DIV_STAGES-1];
    assign o_by  = r_qy[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/sbpr_color.sv =====
`default_nettype none

// Face colour scaled by brightness / 255, recomputed continuously from the
// registers over three stages.
module sbpr_color
    import sbpr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire t_cfg  i_cfg,
    output logic [15:0] o_rgb565,
    output logic [23:0] o_rgb888
);

    logic [15:0] r_prod [3];
    logic [15:0] r_prod_d [3];
    logic [7:0]  r_est [3];
    logic [7:0]  r_chan [3];
    logic [7:0]  n_chan [3];
    logic [7:0]  n_est [3];
    logic [7:0]  chan_in [3];

    assign chan_in[0] = i_cfg.base_color[23:16];
    assign chan_in[1] = i_cfg.base_color[15:8];
    assign chan_in[2] = i_cfg.base_color[7:0];

    // Estimate (p + p/256) / 256 is at most one below p / 255; one
    // compare on the remainder fixes it.
    always_comb begin
        logic [16:0] sum;
        logic [15:0] rem;
        for (int c = 0; c < 3; c++) begin
            sum       = 17'(r_prod[c]) + 17'(r_prod[c] >> 8);
            n_est[c]  = sum[15:8];
            rem       = r_prod_d[c] - ((16'(r_est[c]) << 8) - 16'(r_est[c]));
            n_chan[c] = (rem >= 16'd255) ? r_est[c] + 8'd1 : r_est[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_prod[c]   <= 16'(chan_in[c]) * 16'(i_cfg.brightness);
            r_prod_d[c] <= r_prod[c];
            r_est[c]    <= n_est[c];
            r_chan[c]   <= n_chan[c];
        end
    end

    assign o_rgb565 = {r_chan[0][7:3], r_chan[1][7:2], r_chan[2][7:3]};
    assign o_rgb888 = {r_chan[0], r_chan[1], r_chan[2]};

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_bitmap_pixel_render.sv =====
// Nearest-neighbor renderer of 1-bit face bitmaps, one screen pixel per beat.
// i_pix carries input beats: mode 0 writes one bitmap byte into the store,
// mode 1 asks for the pixel at (screen_x, screen_y). Only fetch beats give a
// result beat on o_pix: lit, and the colour as RGB565 and RGB888 (zero
// when the pixel is black). i_cfg writes the eight registers by index; it is
// always ready, and a write applies to every beat accepted after it.
// Throughput is one beat per cycle while the skid register is empty. A fetch
// result passes the window registers, the stages of the coordinate dividers
// (two quotient bits per stage), the address register and the registered read
// of the bitmap RAM before it reaches the output register. A load written in
// the RAM stage is seen by every fetch accepted after it.
// Reset clears all valid bits and restores the register defaults; bitmap
// contents are undefined until written and need no clearing.
// When the receiver stalls, one further result lands in a skid register and
// i_pix.ready then drops; the pipeline holds in place and nothing is lost.
`default_nettype none

`include "scaled_bitmap_pixel_render_assert.svh"

module scaled_bitmap_pixel_render
    import sbpr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbpr_in_if.sink     i_pix,
    sbpr_out_if.source  o_pix,
    sbpr_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;

    logic en;
    logic accept;

    t_item             item;
    logic              win_vld;
    t_tag              win_tag;
    logic [FACE_W-1:0] win_lx, win_ly, win_fw, win_fh;

    logic            scl_vld;
    t_tag            scl_tag;
    logic [BX_W-1:0] scl_bx;
    logic [BY_W-1:0] scl_by;

    logic              r_r_vld;
    t_tag              r_r_tag;
    logic              r_r_imgok;
    logic [2:0]        r_r_bit;
    logic [ADDR_W-1:0] n_r_addr;

    logic       r_m_vld;
    logic       r_m_fetch;
    logic       r_m_inwin;
    logic       r_m_imgok;
    logic [2:0] r_m_bit;

    logic              ram_we, ram_re;
    logic [7:0]        ram_rdata;
    logic [15:0]       rgb565;
    logic [23:0]       rgb888;

    logic pix_bit, push;
    t_pix n_pix;
    logic r_o_vld, r_k_vld;
    t_pix r_o, r_k;

    // Register file.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.face_width   <= 8'd224;
            r_cfg.face_height  <= 8'd112;
            r_cfg.base_color   <= 24'h00d7ff;
            r_cfg.shift_x      <= 8'sd0;
            r_cfg.shift_y      <= 8'sd0;
            r_cfg.brightness   <= 8'd255;
            r_cfg.invert       <= 1'b0;
            r_cfg.image_select <= 4'd0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FACE_WIDTH:   r_cfg.face_width   <= i_cfg.data[7:0];
                CFG_FACE_HEIGHT:  r_cfg.face_height  <= i_cfg.data[7:0];
                CFG_BASE_COLOR:   r_cfg.base_color   <= i_cfg.data[23:0];
                CFG_SHIFT_X:      r_cfg.shift_x      <= $signed(i_cfg.data[7:0]);
                CFG_SHIFT_Y:      r_cfg.shift_y      <= $signed(i_cfg.data[7:0]);
                CFG_BRIGHTNESS:   r_cfg.brightness   <= i_cfg.data[7:0];
                CFG_INVERT:       r_cfg.invert       <= i_cfg.data[0];
                CFG_IMAGE_SELECT: r_cfg.image_select <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // The stages up to the RAM read advance together unless the skid register is full.
    assign en          = !r_k_vld;
    assign i_pix.ready = en;
    assign accept      = i_pix.valid && en;

    assign item = '{
        mode:            i_pix.mode,
        image_slot:      i_pix.image_slot,
        bitmap_row:      i_pix.bitmap_row,
        bitmap_byte_col: i_pix.bitmap_byte_col,
        bitmap_data:     i_pix.bitmap_data,
        screen_x:        i_pix.screen_x,
        screen_y:        i_pix.screen_y
    };

    sbpr_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (accept),
        .i_item  (item),
        .o_vld   (win_vld),
        .o_tag   (win_tag),
        .o_lx    (win_lx),
        .o_ly    (win_ly),
        .o_fw    (win_fw),
        .o_fh    (win_fh)
    );

    sbpr_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (win_vld),
        .i_tag   (win_tag),
        .i_lx    (win_lx),
        .i_ly    (win_ly),
        .i_fw    (win_fw),
        .i_fh    (win_fh),
        .o_vld   (scl_vld),
        .o_tag   (scl_tag),
        .o_bx    (scl_bx),
        .o_by    (scl_by)
    );

    sbpr_color u_color (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .o_rgb565 (rgb565),
        .o_rgb888 (rgb888)
    );

    // Address stage: a fetch turns its bitmap coordinate into a byte address; a load keeps its own.
    assign n_r_addr = scl_tag.fetch
        ? ADDR_W'((32'(r_cfg.image_select) * BITMAP_HEIGHT + 32'(scl_by)) * ROW_BYTES
                  + 32'(scl_bx >> 3))
        : scl_tag.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_r_vld <= scl_vld;
            r_m_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_tag.fetch <= scl_tag.fetch;
            r_r_tag.act   <= scl_tag.act;
            r_r_tag.addr  <= n_r_addr;
            r_r_tag.data  <= scl_tag.data;
            r_r_imgok     <= (32'(r_cfg.image_select) < IMAGE_COUNT);
            r_r_bit       <= scl_bx[2:0];
            r_m_fetch     <= r_r_tag.fetch;
            r_m_inwin     <= r_r_tag.act;
            r_m_imgok     <= r_r_imgok;
            r_m_bit       <= r_r_bit;
        end
    end

    // Loads and fetches share this stage, so store order is kept.
    assign ram_we = en && r_r_vld && !r_r_tag.fetch && r_r_tag.act;
    assign ram_re = en && r_r_vld && r_r_tag.fetch && r_r_tag.act && r_r_imgok;

    sbpr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_r_tag.addr),
        .i_wdata (r_r_tag.data),
        .i_re    (ram_re),
        .i_raddr (r_r_tag.addr),
        .o_rdata (ram_rdata)
    );

    // Bit 7 of a byte is the leftmost pixel.
    assign pix_bit = ram_rdata[3'd7 - r_m_bit];

    always_comb begin
        n_pix.lit        = r_m_inwin && ((r_m_imgok && pix_bit) ^ r_cfg.invert);
        n_pix.pixel_565  = n_pix.lit ? rgb565 : 16'd0;
        n_pix.pixel_8888 = n_pix.lit ? rgb888 : 24'd0;
    end

    assign push = en && r_m_vld && r_m_fetch;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else if (!r_o_vld || o_pix.ready) begin
            if (r_k_vld) begin
                r_o_vld <= 1'b1;
                r_k_vld <= 1'b0;
            end else begin
                r_o_vld <= push;
            end
        end else if (push) begin
            r_k_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || o_pix.ready) begin
            r_o <= r_k_vld ? r_k : n_pix;
        end else if (push) begin
            r_k <= n_pix;
        end
    end

    assign o_pix.valid      = r_o_vld;
    assign o_pix.lit        = r_o.lit;
    assign o_pix.pixel_565  = r_o.pixel_565;
    assign o_pix.pixel_8888 = r_o.pixel_8888;

    `SBPR_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_k_vld, r_o_vld)
    `SBPR_ASSERT_IMPL(a_ram_one_access, i_clk, i_rst_n, ram_we, !ram_re)
    `SBPR_ASSERT_IMPL(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_k_vld), $past(r_o_vld && !o_pix.ready))
    `SBPR_ASSERT_IMPL(a_dark_is_black, i_clk, i_rst_n, r_o_vld && !r_o.lit, (r_o.pixel_565 == 16'd0) && (r_o.pixel_8888 == 24'd0))
    `SBPR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !en, $stable(r_m_vld) && $stable(r_r_vld))

endmodule

`default_nettype wire

// ===== bench/pixel_render_check.sv =====
module pixel_render_check
    import sbpr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbpr_in_if        i_pix,
    sbpr_out_if       i_res,
    sbpr_cfg_if       i_cfg,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cfg RESET_SETTING = '{
        face_width: 8'd224, face_height: 8'd112, base_color: 24'h00d7ff,
        shift_x: 8'sd0, shift_y: 8'sd0, brightness: 8'd255, invert: 1'b0,
        image_select: 4'd0
    };
    localparam int PRINT_LIMIT = 40;

    t_cfg       face_cfg = RESET_SETTING;
    logic [7:0] bitmap [STORE_SIZE];
    t_pix       expected_pixels [$];
    t_pix       got_pixel;
    t_pix       want_pixel;
    int         mismatches = 0;
    int         results_checked = 0;

    task automatic report(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("%t ns: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic int face_extent(input logic [7:0] size, input int screen);
        if (size < 1) begin
            return 1;
        end
        if (size > screen) begin
            return screen;
        end
        return size;
    endfunction

    function automatic logic [7:0] scale_channel(input logic [7:0] c);
        return 8'((int'(c) * int'(face_cfg.brightness)) / 255);
    endfunction

    // Nearest-neighbor sample of the selected image at one screen position.
    function automatic t_pix render_pixel(input logic [7:0] sx, input logic [7:0] sy);
        t_pix       px;
        int         fw;
        int         fh;
        int         lx;
        int         ly;
        int         bx;
        int         by;
        logic [7:0] bits;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        px = '0;
        if (sx >= SCREEN_WIDTH || sy >= SCREEN_HEIGHT) begin
            return px;
        end
        fw = face_extent(face_cfg.face_width, SCREEN_WIDTH);
        fh = face_extent(face_cfg.face_height, SCREEN_HEIGHT);
        lx = int'(sx) - ((SCREEN_WIDTH - fw) / 2 + int'(face_cfg.shift_x));
        ly = int'(sy) - ((SCREEN_HEIGHT - fh) / 2 + int'(face_cfg.shift_y));
        if (lx < 0 || ly < 0 || lx >= fw || ly >= fh) begin
            return px;
        end
        bx = lx * BITMAP_WIDTH / fw;
        by = ly * BITMAP_HEIGHT / fh;
        bits = bitmap[(int'(face_cfg.image_select) * BITMAP_HEIGHT + by) * ROW_BYTES + bx / 8];
        if ((bits[7 - bx % 8] ^ face_cfg.invert) == 1'b0) begin
            return px;
        end
        r = scale_channel(face_cfg.base_color[23:16]);
        g = scale_channel(face_cfg.base_color[15:8]);
        b = scale_channel(face_cfg.base_color[7:0]);
        px.lit        = 1'b1;
        px.pixel_565  = {r[7:3], g[7:2], b[7:3]};
        px.pixel_8888 = {r, g, b};
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            face_cfg = RESET_SETTING;
            expected_pixels.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_pixel = '{lit: i_res.lit, pixel_565: i_res.pixel_565,
                              pixel_8888: i_res.pixel_8888};
                if (expected_pixels.size() == 0) begin
                    report($sformatf("result beat %0d arrived with no fetch waiting",
                                     results_checked));
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (got_pixel.lit !== want_pixel.lit) begin
                        report($sformatf("result %0d lit: got %b expected %b",
                                         results_checked, got_pixel.lit, want_pixel.lit));
                    end
                    if (got_pixel.pixel_565 !== want_pixel.pixel_565) begin
                        report($sformatf("result %0d pixel_565: got %h expected %h",
                                         results_checked, got_pixel.pixel_565,
                                         want_pixel.pixel_565));
                    end
                    if (got_pixel.pixel_8888 !== want_pixel.pixel_8888) begin
                        report($sformatf("result %0d pixel_8888: got %h expected %h",
                                         results_checked, got_pixel.pixel_8888,
                                         want_pixel.pixel_8888));
                    end
                end
                results_checked++;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FACE_WIDTH:   face_cfg.face_width   = i_cfg.data[7:0];
                    CFG_FACE_HEIGHT:  face_cfg.face_height  = i_cfg.data[7:0];
                    CFG_BASE_COLOR:   face_cfg.base_color   = i_cfg.data;
                    CFG_SHIFT_X:      face_cfg.shift_x      = i_cfg.data[7:0];
                    CFG_SHIFT_Y:      face_cfg.shift_y      = i_cfg.data[7:0];
                    CFG_BRIGHTNESS:   face_cfg.brightness   = i_cfg.data[7:0];
                    CFG_INVERT:       face_cfg.invert       = i_cfg.data[0];
                    CFG_IMAGE_SELECT: face_cfg.image_select = i_cfg.data[3:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.mode == MODE_LOAD) begin
                    bitmap[(int'(i_pix.image_slot) * BITMAP_HEIGHT + int'(i_pix.bitmap_row))
                           * ROW_BYTES + int'(i_pix.bitmap_byte_col)] = i_pix.bitmap_data;
                end else begin
                    expected_pixels.push_back(render_pixel(i_pix.screen_x, i_pix.screen_y));
                end
            end
        end
        o_pending <= expected_pixels.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import sbpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1650;
    localparam int QUIET_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_GAP       = 14;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    localparam t_cfg RESET_SETTING = '{
        face_width: 8'd224, face_height: 8'd112, base_color: 24'h00d7ff,
        shift_x: 8'sd0, shift_y: 8'sd0, brightness: 8'd255, invert: 1'b0,
        image_select: 4'd0
    };

    logic clk;
    logic rst_n;

    sbpr_in_if  pix_in ();
    sbpr_out_if pix_out ();
    sbpr_cfg_if cfg_if ();

    int   pixel_errors;
    int   pixel_pending;
    t_cfg cur_cfg = RESET_SETTING;
    bit   loaded [STORE_SIZE];
    int   src_style  = IDLE_NONE;
    int   sink_style = IDLE_NONE;
    int   beats_sent = 0;
    int   fetches_sent = 0;
    int   settings_done = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;

    scaled_bitmap_pixel_render dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_if)
    );

    pixel_render_check pixel_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_pix     (pix_in),
        .i_res     (pix_out),
        .i_cfg     (cfg_if),
        .o_errors  (pixel_errors),
        .o_pending (pixel_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_gap(input int style);
        case (style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            default:    return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    function automatic int face_extent(input logic [7:0] size, input int screen);
        if (size < 1) begin
            return 1;
        end
        if (size > screen) begin
            return screen;
        end
        return size;
    endfunction

    function automatic int window_origin(input int extent, input logic signed [7:0] shift,
                                         input int screen);
        return (screen - extent) / 2 + int'(shift);
    endfunction

    // Store entry that a fetch at (sx, sy) reads, or -1 when it reads none.
    function automatic int bitmap_entry(input logic [7:0] sx, input logic [7:0] sy);
        int fw;
        int fh;
        int lx;
        int ly;
        fw = face_extent(cur_cfg.face_width, SCREEN_WIDTH);
        fh = face_extent(cur_cfg.face_height, SCREEN_HEIGHT);
        lx = int'(sx) - window_origin(fw, cur_cfg.shift_x, SCREEN_WIDTH);
        ly = int'(sy) - window_origin(fh, cur_cfg.shift_y, SCREEN_HEIGHT);
        if (sx >= SCREEN_WIDTH || sy >= SCREEN_HEIGHT || lx < 0 || ly < 0 ||
            lx >= fw || ly >= fh) begin
            return -1;
        end
        return (int'(cur_cfg.image_select) * BITMAP_HEIGHT + ly * BITMAP_HEIGHT / fh)
               * ROW_BYTES + lx * BITMAP_WIDTH / fw / 8;
    endfunction

    // About half inside the window, some just outside its borders, the rest anywhere.
    function automatic logic [7:0] pick_coord(input int origin, input int extent);
        int v;
        case ($urandom_range(0, 7))
            0, 1:    v = $urandom_range(0, 255);
            2:       v = origin - 1;
            3:       v = origin + extent;
            default: v = origin + $urandom_range(0, extent - 1);
        endcase
        if (v < 0 || v > 255) begin
            v = $urandom_range(0, 255);
        end
        return 8'(v);
    endfunction

    function automatic logic [7:0] pick_face_size();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'($urandom_range(2, 16));
            3:       return 8'(SCREEN_WIDTH);
            4:       return 8'($urandom_range(241, 255));
            default: return 8'($urandom_range(17, 239));
        endcase
    endfunction

    function automatic logic [7:0] pick_shift();
        case ($urandom_range(0, 5))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_cfg random_setting(input int phase);
        t_cfg c;
        c.face_width  = pick_face_size();
        c.face_height = pick_face_size();
        case ($urandom_range(0, 4))
            0:       c.base_color = 24'h000000;
            1:       c.base_color = 24'hffffff;
            default: c.base_color = 24'($urandom);
        endcase
        c.shift_x = pick_shift();
        c.shift_y = pick_shift();
        case ($urandom_range(0, 4))
            0:       c.brightness = 8'd0;
            1:       c.brightness = 8'd255;
            default: c.brightness = 8'($urandom_range(0, 255));
        endcase
        c.invert       = 1'($urandom_range(0, 1));
        c.image_select = 4'(phase % IMAGE_COUNT);
        return c;
    endfunction

    task automatic send_beat(input t_item it);
        int gap;
        gap = idle_gap(src_style);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.mode            <= it.mode;
        pix_in.image_slot      <= it.image_slot;
        pix_in.bitmap_row      <= it.bitmap_row;
        pix_in.bitmap_byte_col <= it.bitmap_byte_col;
        pix_in.bitmap_data     <= it.bitmap_data;
        pix_in.screen_x        <= it.screen_x;
        pix_in.screen_y        <= it.screen_y;
        pix_in.valid           <= 1'b1;
        do @(posedge clk); while (!(pix_in.valid && pix_in.ready));
        beats_sent++;
    endtask

    task automatic load_byte(input int slot, input int row, input int col,
                             input logic [7:0] data);
        t_item it;
        it.mode            = MODE_LOAD;
        it.image_slot      = 4'(slot);
        it.bitmap_row      = 6'(row);
        it.bitmap_byte_col = 4'(col);
        it.bitmap_data     = data;
        it.screen_x        = 8'($urandom);
        it.screen_y        = 8'($urandom);
        send_beat(it);
        loaded[(slot * BITMAP_HEIGHT + row) * ROW_BYTES + col] = 1'b1;
    endtask

    // A fetch that would sample a byte never written gets that byte loaded first.
    task automatic fetch_pixel(input logic [7:0] sx, input logic [7:0] sy);
        int    entry;
        t_item it;
        entry = bitmap_entry(sx, sy);
        if (entry >= 0 && !loaded[entry]) begin
            load_byte(entry / (BITMAP_HEIGHT * ROW_BYTES), (entry / ROW_BYTES) % BITMAP_HEIGHT,
                      entry % ROW_BYTES, 8'($urandom));
        end
        it.mode            = MODE_FETCH;
        it.image_slot      = 4'($urandom);
        it.bitmap_row      = 6'($urandom);
        it.bitmap_byte_col = 4'($urandom);
        it.bitmap_data     = 8'($urandom);
        it.screen_x        = sx;
        it.screen_y        = sy;
        send_beat(it);
        fetches_sent++;
    endtask

    task automatic wait_results();
        pix_in.valid <= 1'b0;
        do @(posedge clk); while (pixel_pending != 0);
    endtask

    // Bits above the register width carry random values.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value, input int width);
        int unsigned mask;
        mask = (32'd1 << width) - 1;
        cfg_if.index <= idx;
        cfg_if.data  <= 24'(($urandom & ~mask) | (value & mask));
        cfg_if.valid <= 1'b1;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_FACE_WIDTH, c.face_width, 8);
        write_reg(CFG_FACE_HEIGHT, c.face_height, 8);
        write_reg(CFG_BASE_COLOR, c.base_color, 24);
        write_reg(CFG_SHIFT_X, c.shift_x, 8);
        write_reg(CFG_SHIFT_Y, c.shift_y, 8);
        write_reg(CFG_BRIGHTNESS, c.brightness, 8);
        write_reg(CFG_INVERT, c.invert, 1);
        write_reg(CFG_IMAGE_SELECT, c.image_select, 4);
        cfg_if.valid <= 1'b0;
        cur_cfg = c;
        settings_done++;
    endtask

    // Result side: a random stall before each beat, then ready held until it is taken.
    initial begin
        int gap;
        pix_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = idle_gap(sink_style);
            if (gap > 0) begin
                pix_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge clk); while (!(pix_out.valid && pix_out.ready));
        end
    end

    always @(posedge clk) begin
        if (pix_out.valid && pix_out.ready && rst_n) begin
            results_seen <= results_seen + 1;
        end
        if (!rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg setting;
        int   phase;
        int   n;
        int   fw;
        int   fh;
        int   entries;
        rst_n                  <= 1'b0;
        pix_in.valid           <= 1'b0;
        pix_in.mode            <= MODE_LOAD;
        pix_in.image_slot      <= '0;
        pix_in.bitmap_row      <= '0;
        pix_in.bitmap_byte_col <= '0;
        pix_in.bitmap_data     <= '0;
        pix_in.screen_x        <= '0;
        pix_in.screen_y        <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= CFG_FACE_WIDTH;
        cfg_if.data            <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a 224 by 112 window whose corner sits at (8, 64).
        load_byte(0, 0, 0, 8'hff);
        load_byte(IMAGE_COUNT - 1, BITMAP_HEIGHT - 1, ROW_BYTES - 1, 8'h00);
        load_byte(0, BITMAP_HEIGHT - 1, ROW_BYTES - 1, 8'h01);
        fetch_pixel(8'd8, 8'd64);
        fetch_pixel(8'd231, 8'd175);
        fetch_pixel(8'd230, 8'd175);
        fetch_pixel(8'd7, 8'd64);
        fetch_pixel(8'd232, 8'd64);
        fetch_pixel(8'd8, 8'd63);
        fetch_pixel(8'd8, 8'd176);
        fetch_pixel(8'd255, 8'd255);
        fetch_pixel(8'd240, 8'd100);
        fetch_pixel(8'd100, 8'd240);
        fetch_pixel(8'd239, 8'd239);
        fetch_pixel(8'd0, 8'd0);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            case (phase)
                0: setting = '{face_width: 8'd240, face_height: 8'd240,
                               base_color: 24'hffffff, shift_x: 8'sd0, shift_y: 8'sd0,
                               brightness: 8'd255, invert: 1'b0, image_select: 4'd15};
                1: setting = '{face_width: 8'd0, face_height: 8'd0,
                               base_color: 24'h5a3cc3, shift_x: 8'sd0, shift_y: 8'sd0,
                               brightness: 8'd0, invert: 1'b1, image_select: 4'd0};
                2: setting = '{face_width: 8'd255, face_height: 8'd1,
                               base_color: 24'($urandom), shift_x: 8'h80, shift_y: 8'h7f,
                               brightness: 8'd128, invert: 1'b0, image_select: 4'd1};
                3: setting = '{face_width: 8'd1, face_height: 8'd255,
                               base_color: 24'h000000, shift_x: 8'h7f, shift_y: 8'h80,
                               brightness: 8'd1, invert: 1'b1, image_select: 4'd2};
                default: setting = random_setting(phase);
            endcase
            program_regs(setting);
            src_style  = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            sink_style = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            fw = face_extent(cur_cfg.face_width, SCREEN_WIDTH);
            fh = face_extent(cur_cfg.face_height, SCREEN_HEIGHT);
            n = $urandom_range(40, 110);
            repeat (n) begin
                case ($urandom_range(0, 39))
                    0: wait_results();
                    1, 2, 3, 4, 5, 6, 7, 8:
                        load_byte($urandom_range(0, 1) ? int'(cur_cfg.image_select)
                                                       : $urandom_range(0, IMAGE_COUNT - 1),
                                  $urandom_range(0, BITMAP_HEIGHT - 1),
                                  $urandom_range(0, ROW_BYTES - 1), 8'($urandom));
                    default:
                        fetch_pixel(
                            pick_coord(window_origin(fw, cur_cfg.shift_x, SCREEN_WIDTH), fw),
                            pick_coord(window_origin(fh, cur_cfg.shift_y, SCREEN_HEIGHT), fh));
                endcase
            end
            wait_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            phase++;
        end

        entries = 0;
        foreach (loaded[i]) begin
            entries += loaded[i];
        end
        $display("summary: %0d input beats, %0d of them pixel fetches, %0d result beats,",
                 beats_sent, fetches_sent, results_seen);
        $display("summary: %0d register settings, %0d of %0d bitmap bytes written",
                 settings_done, entries, STORE_SIZE);
        if (pixel_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sbpr_pkg.sv
hw/rtl/sbpr_if.sv
hw/rtl/sbpr_ram.sv
hw/rtl/sbpr_window.sv
hw/rtl/sbpr_scaler.sv
hw/rtl/sbpr_color.sv
hw/rtl/scaled_bitmap_pixel_render.sv
bench/pixel_render_check.sv
bench/testbench.sv
